### sv/cbmd_pkg.sv
// Package for the minimum-distance block code decoder.
// Holds widths, codes, state encoding and helper functions; no dependencies.
package cbmd_pkg;

  localparam int unsigned MaxCodeLength    = 32;
  localparam int unsigned MaxMessageLength = 8;

  localparam int unsigned CodeW    = 32;
  localparam int unsigned MsgW     = 8;
  localparam int unsigned DistW    = 6;
  localparam int unsigned NLenW    = 6;
  localparam int unsigned KLenW    = 4;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned Depth    = 256;

  localparam logic [NLenW-1:0] CodeLengthReset    = NLenW'(7);
  localparam logic [KLenW-1:0] MessageLengthReset = KLenW'(4);

  localparam logic [CfgIdxW-1:0] CfgCodeLength    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMessageLength = CfgIdxW'(1);

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_DECODE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENC,
    S_DEC,
    S_DONE
  } state_e;

  function automatic logic [DistW-1:0] ones_count(input logic [CodeW-1:0] v);
    logic [DistW-1:0] c;
    c = '0;
    for (int i = 0; i < CodeW; i++) begin
      c = c + DistW'(v[i]);
    end
    return c;
  endfunction

  function automatic logic [CodeW-1:0] n_mask(input logic [NLenW-1:0] n);
    logic [CodeW:0] m;
    m = (CodeW+1)'(1) << n;
    return CodeW'(m - (CodeW+1)'(1));
  endfunction

  function automatic logic [MsgW-1:0] k_mask(input logic [KLenW-1:0] k);
    logic [MsgW:0] m;
    m = (MsgW+1)'(1) << k;
    return MsgW'(m - (MsgW+1)'(1));
  endfunction

endpackage

### sv/codebook_block_code_min_distance.sv
// Flow: load and unused beats pass straight to S_DONE; encode reads the codeword,
// then takes it in S_ENC; decode scans all 2^k codewords in S_DEC; S_DONE loads
// the output register, held while the output stalls. One item at a time; decode
// reads one codebook word per cycle from the single-port memory.
// Reset: control and length registers return to n = 7, k = 4; the codebook
// memory is not cleared and holds undefined data until each entry is loaded.
module codebook_block_code_min_distance (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cbmd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [cbmd_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       func_i,
  input  logic [cbmd_pkg::MsgW-1:0]        entry_index_i,
  input  logic [cbmd_pkg::CodeW-1:0]       entry_word_i,
  input  logic [cbmd_pkg::MsgW-1:0]        message_i,
  input  logic [cbmd_pkg::CodeW-1:0]       received_hard_i,
  input  logic                             block_is_last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [cbmd_pkg::CodeW-1:0]       codeword_o,
  output logic [cbmd_pkg::MsgW-1:0]        message_out_o,
  output logic [cbmd_pkg::DistW-1:0]       min_distance_o,
  output logic                             last_block_o
);

  cbmd_pkg::state_e state_q, state_d;

  logic [cbmd_pkg::NLenW-1:0] code_length_q;
  logic [cbmd_pkg::KLenW-1:0] message_length_q;
  logic [cbmd_pkg::NLenW-1:0] n_eff;
  logic [cbmd_pkg::KLenW-1:0] k_eff;
  logic [cbmd_pkg::CodeW-1:0] nmask;
  logic [cbmd_pkg::MsgW-1:0]  kmask;

  logic [cbmd_pkg::CodeW-1:0] mem [cbmd_pkg::Depth];
  logic [cbmd_pkg::CodeW-1:0] rd_data_q;
  logic [cbmd_pkg::MsgW-1:0]  rd_addr;
  logic                       rd_en;

  logic                       in_fire;
  logic                       done_take;
  logic [cbmd_pkg::MsgW-1:0]  cur_q;
  logic [cbmd_pkg::CodeW-1:0] rx_q;
  logic                       last_q;
  logic [cbmd_pkg::CodeW-1:0] res_cw_q;
  logic [cbmd_pkg::MsgW-1:0]  res_msg_q;
  logic [cbmd_pkg::DistW-1:0] res_dist_q;
  logic [cbmd_pkg::DistW-1:0] cand_dist;
  logic [cbmd_pkg::CodeW-1:0] rd_masked;
  logic                       out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;

  assign n_eff = (code_length_q > cbmd_pkg::NLenW'(cbmd_pkg::MaxCodeLength)) ?
                 cbmd_pkg::NLenW'(cbmd_pkg::MaxCodeLength) : code_length_q;
  assign k_eff = (message_length_q > cbmd_pkg::KLenW'(cbmd_pkg::MaxMessageLength)) ?
                 cbmd_pkg::KLenW'(cbmd_pkg::MaxMessageLength) : message_length_q;
  assign nmask = cbmd_pkg::n_mask(n_eff);
  assign kmask = cbmd_pkg::k_mask(k_eff);

  assign rd_masked = rd_data_q & nmask;
  assign cand_dist = cbmd_pkg::ones_count((rx_q ^ rd_data_q) & nmask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_length_q    <= cbmd_pkg::CodeLengthReset;
      message_length_q <= cbmd_pkg::MessageLengthReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cbmd_pkg::CfgCodeLength:    code_length_q    <= cfg_data_i[cbmd_pkg::NLenW-1:0];
        cbmd_pkg::CfgMessageLength: message_length_q <= cfg_data_i[cbmd_pkg::KLenW-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cbmd_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (func_i)
            cbmd_pkg::FUNC_ENCODE: state_d = cbmd_pkg::S_ENC;
            cbmd_pkg::FUNC_DECODE: state_d = cbmd_pkg::S_DEC;
            default:               state_d = cbmd_pkg::S_DONE;
          endcase
        end
      end
      cbmd_pkg::S_ENC: state_d = cbmd_pkg::S_DONE;
      cbmd_pkg::S_DEC: begin
        if (cur_q == kmask) begin
          state_d = cbmd_pkg::S_DONE;
        end
      end
      cbmd_pkg::S_DONE: begin
        if (done_take) begin
          state_d = cbmd_pkg::S_IDLE;
        end
      end
      default: state_d = cbmd_pkg::S_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    done_take  = 1'b0;
    unique case (state_q)
      cbmd_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        rd_en      = (func_i != cbmd_pkg::FUNC_LOAD);
        rd_addr    = (func_i == cbmd_pkg::FUNC_ENCODE) ? (message_i & kmask) : '0;
      end
      cbmd_pkg::S_ENC: ;
      cbmd_pkg::S_DEC: begin
        rd_en   = 1'b1;
        rd_addr = cur_q + cbmd_pkg::MsgW'(1);
      end
      cbmd_pkg::S_DONE: done_take = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbmd_pkg::S_IDLE;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        cur_q <= '0;
      end else if (state_q == cbmd_pkg::S_DEC) begin
        cur_q <= cur_q + cbmd_pkg::MsgW'(1);
      end
      if (done_take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && func_i == cbmd_pkg::FUNC_LOAD) begin
      mem[entry_index_i] <= entry_word_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rx_q       <= received_hard_i;
      last_q     <= block_is_last_i;
      res_cw_q   <= '0;
      res_msg_q  <= '0;
      res_dist_q <= '0;
    end else if (state_q == cbmd_pkg::S_ENC) begin
      res_cw_q <= rd_masked;
    end else if (state_q == cbmd_pkg::S_DEC) begin
      if (cur_q == '0 || cand_dist < res_dist_q) begin
        res_cw_q   <= rd_masked;
        res_msg_q  <= cur_q;
        res_dist_q <= cand_dist;
      end
    end
    if (done_take) begin
      codeword_o     <= res_cw_q;
      message_out_o  <= res_msg_q;
      min_distance_o <= res_dist_q;
      last_block_o   <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cbmd_pkg::S_DEC |-> cur_q <= kmask)
    else $error("decode scan index past codebook size");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbmd_pkg::S_DONE && out_valid_q && !out_ready_i) |=>
    state_q == cbmd_pkg::S_DONE)
    else $error("pending result dropped while output stalled");

  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> min_distance_o <= cbmd_pkg::DistW'(n_eff))
    else $error("distance exceeds code length");

  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == cbmd_pkg::S_DONE)
    else $error("result issued outside completion state");
`endif

endmodule

### tb/sv/codebook_block_code_min_distance_test.sv
// Self-checking testbench for the minimum-distance block code decoder.
// Drives load, encode, decode and unused beats under several length settings and
// checks each result against a predictor or stored gold; needs cbmd_pkg and RTL.
`timescale 1ns / 1ps

module codebook_block_code_min_distance_test;

  localparam logic [1:0] FuncUnused = 2'd3;
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned DrainCycles = 270;

  typedef struct packed {
    logic [cbmd_pkg::CodeW-1:0] codeword;
    logic [cbmd_pkg::MsgW-1:0]  message;
    logic [cbmd_pkg::DistW-1:0] distance;
    logic                       last;
  } answer_t;

  typedef struct packed {
    logic [1:0]                 func;
    logic [cbmd_pkg::MsgW-1:0]  index;
    logic [cbmd_pkg::CodeW-1:0] word;
    logic [cbmd_pkg::MsgW-1:0]  message;
    logic [cbmd_pkg::CodeW-1:0] received;
    logic                       last;
    logic                       gold_on;
    answer_t                    gold;
  } beat_t;

  typedef struct {
    logic [cbmd_pkg::CfgDataW-1:0] n_data;
    logic [cbmd_pkg::CfgDataW-1:0] k_data;
    int                            count;
    bit                            steady;
  } phase_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [cbmd_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [cbmd_pkg::CfgDataW-1:0] cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [1:0]                    func_i;
  logic [cbmd_pkg::MsgW-1:0]     entry_index_i;
  logic [cbmd_pkg::CodeW-1:0]    entry_word_i;
  logic [cbmd_pkg::MsgW-1:0]     message_i;
  logic [cbmd_pkg::CodeW-1:0]    received_hard_i;
  logic                          block_is_last_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [cbmd_pkg::CodeW-1:0]    codeword_o;
  logic [cbmd_pkg::MsgW-1:0]     message_out_o;
  logic [cbmd_pkg::DistW-1:0]    min_distance_o;
  logic                          last_block_o;

  logic [cbmd_pkg::CodeW-1:0] book [cbmd_pkg::Depth];
  int               n_len;
  int               k_len;
  answer_t          pending_answers [$];
  beat_t            cur_beat;
  beat_t            directed_rows [$];
  phase_t           phases [11];
  bit               steady;
  int               mismatches;
  int unsigned      cycles;

  codebook_block_code_min_distance i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .entry_index_i   (entry_index_i),
    .entry_word_i    (entry_word_i),
    .message_i       (message_i),
    .received_hard_i (received_hard_i),
    .block_is_last_i (block_is_last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .codeword_o      (codeword_o),
    .message_out_o   (message_out_o),
    .min_distance_o  (min_distance_o),
    .last_block_o    (last_block_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic answer_t min_distance_answer(input beat_t b);
    answer_t                    r;
    logic [cbmd_pkg::CodeW-1:0] mask;
    int                         best;
    int                         best_d;
    int                         d;
    r = '0;
    r.last = b.last;
    mask = (n_len >= 32) ? '1 : cbmd_pkg::CodeW'((64'd1 << n_len) - 64'd1);
    case (b.func)
      cbmd_pkg::FUNC_LOAD: begin
        book[b.index] = b.word;
      end
      cbmd_pkg::FUNC_ENCODE: begin
        r.codeword = book[b.message & cbmd_pkg::MsgW'((1 << k_len) - 1)] & mask;
      end
      cbmd_pkg::FUNC_DECODE: begin
        best = 0;
        best_d = $countones((b.received ^ book[0]) & mask);
        for (int j = 1; j < (1 << k_len); j++) begin
          d = $countones((b.received ^ book[j]) & mask);
          if (d < best_d) begin
            best_d = d;
            best = j;
          end
        end
        r.codeword = book[best] & mask;
        r.message = cbmd_pkg::MsgW'(best);
        r.distance = cbmd_pkg::DistW'(best_d);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic beat_t row(input logic [1:0] func,
                                input logic [cbmd_pkg::MsgW-1:0] index,
                                input logic [cbmd_pkg::CodeW-1:0] word,
                                input logic [cbmd_pkg::MsgW-1:0] message,
                                input logic [cbmd_pkg::CodeW-1:0] received, input logic last,
                                input logic gold_on, input logic [cbmd_pkg::CodeW-1:0] cw,
                                input logic [cbmd_pkg::MsgW-1:0] mo,
                                input logic [cbmd_pkg::DistW-1:0] md);
    beat_t b;
    b.func = func;
    b.index = index;
    b.word = word;
    b.message = message;
    b.received = received;
    b.last = last;
    b.gold_on = gold_on;
    b.gold = '{codeword: cw, message: mo, distance: md, last: last};
    return b;
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    int    sel;
    b = row(cbmd_pkg::FUNC_LOAD, cbmd_pkg::MsgW'($urandom), $urandom,
            cbmd_pkg::MsgW'($urandom), $urandom, 1'($urandom), 1'b0, '0, '0, '0);
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      if ($urandom_range(0, 4) == 0) b.word = book[$urandom_range(0, cbmd_pkg::Depth - 1)];
    end else if (sel < 55) begin
      b.func = cbmd_pkg::FUNC_ENCODE;
    end else if (sel < 95) begin
      b.func = cbmd_pkg::FUNC_DECODE;
      if ($urandom_range(0, 1) == 1) begin
        b.received = book[$urandom_range(0, (1 << k_len) - 1)];
        repeat ($urandom_range(0, 3)) begin
          b.received[$urandom_range(0, cbmd_pkg::CodeW - 1)] ^= 1'b1;
        end
      end
    end else begin
      b.func = FuncUnused;
    end
    return b;
  endfunction

  task automatic push_beat(input beat_t b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur_beat = b;
    func_i = b.func;
    entry_index_i = b.index;
    entry_word_i = b.word;
    message_i = b.message;
    received_hard_i = b.received;
    block_is_last_i = b.last;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [cbmd_pkg::CfgIdxW-1:0] index,
                           input logic [cbmd_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == cbmd_pkg::CfgCodeLength) begin
      n_len = (data[5:0] > cbmd_pkg::MaxCodeLength) ? cbmd_pkg::MaxCodeLength : data[5:0];
    end else if (index == cbmd_pkg::CfgMessageLength) begin
      k_len = (data[3:0] > cbmd_pkg::MaxMessageLength) ?
              cbmd_pkg::MaxMessageLength : data[3:0];
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      answer_t a;
      a = min_distance_answer(cur_beat);
      if (cur_beat.gold_on) a = cur_beat.gold;
      pending_answers.push_back(a);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      answer_t a;
      if (pending_answers.size() == 0) begin
        $error("result beat with no expectation pending");
        mismatches++;
      end else begin
        a = pending_answers.pop_front();
        if (codeword_o !== a.codeword) begin
          $error("codeword: expected %h, got %h", a.codeword, codeword_o);
          mismatches++;
        end
        if (message_out_o !== a.message) begin
          $error("message_out: expected %h, got %h", a.message, message_out_o);
          mismatches++;
        end
        if (min_distance_o !== a.distance) begin
          $error("min_distance: expected %0d, got %0d", a.distance, min_distance_o);
          mismatches++;
        end
        if (last_block_o !== a.last) begin
          $error("last_block: expected %b, got %b", a.last, last_block_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(negedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready_i = 1'b0;
        do @(posedge clk_i); while (!out_valid_o);
        repeat (stall - 1) @(posedge clk_i);
        @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    func_i = cbmd_pkg::FUNC_LOAD;
    entry_index_i = '0;
    entry_word_i = '0;
    message_i = '0;
    received_hard_i = '0;
    block_is_last_i = 1'b0;
    mismatches = 0;
    cycles = 0;
    steady = 1'b0;
    n_len = cbmd_pkg::CodeLengthReset;
    k_len = cbmd_pkg::MessageLengthReset;
    cur_beat = '0;

    directed_rows.push_back(row(cbmd_pkg::FUNC_LOAD, 8'd0, 32'h0000_0000, 8'h00, '0, 1'b0,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_LOAD, 8'd1, 32'hFFFF_FFFF, 8'hFF, '1, 1'b1,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_LOAD, 8'd2, 32'h5555_5555, 8'h00, '0, 1'b0,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_LOAD, 8'd3, 32'hAAAA_AAAA, 8'h00, '0, 1'b0,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_LOAD, 8'd4, 32'h0000_0001, 8'h00, '0, 1'b0,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_LOAD, 8'd5, 32'h0000_0002, 8'h00, '0, 1'b0,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_LOAD, 8'd6, 32'h8000_0000, 8'h00, '0, 1'b0,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_LOAD, 8'd7, 32'h1234_5678, 8'h00, '0, 1'b0,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_LOAD, 8'd8, 32'h0000_007E, 8'h00, '0, 1'b0,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_LOAD, 8'd9, 32'hFFFF_FF80, 8'h00, '0, 1'b0,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_LOAD, 8'd10, 32'h0F0F_0F0F, 8'h00, '0, 1'b0,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_LOAD, 8'd11, 32'h7FFF_FFFF, 8'h00, '0, 1'b0,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_LOAD, 8'd12, 32'h0000_0040, 8'h00, '0, 1'b0,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_LOAD, 8'd13, 32'hDEAD_BEEF, 8'h00, '0, 1'b0,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_LOAD, 8'd14, 32'h0000_0030, 8'h00, '0, 1'b0,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_LOAD, 8'd15, 32'h0000_0055, 8'h00, '0, 1'b0,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_LOAD, 8'd255, 32'hCAFE_F00D, 8'h00, '0, 1'b1,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_ENCODE, 8'd0, '0, 8'h00, '0, 1'b0,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_ENCODE, 8'd0, '0, 8'h01, '0, 1'b1,
                                1'b1, 32'h7F, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_ENCODE, 8'd0, '0, 8'hFF, '0, 1'b0,
                                1'b0, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_DECODE, 8'd0, '0, 8'h00, 32'h0, 1'b0,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_DECODE, 8'd0, '0, 8'h00, '1, 1'b1,
                                1'b1, 32'h7F, 8'd1, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_DECODE, 8'd0, '0, 8'h00, 32'hFFFF_FF80, 1'b0,
                                1'b1, '0, '0, '0));
    directed_rows.push_back(row(cbmd_pkg::FUNC_DECODE, 8'd0, '0, 8'h00, 32'h3, 1'b0,
                                1'b0, '0, '0, '0));
    directed_rows.push_back(row(FuncUnused, 8'hFF, '1, 8'hFF, '1, 1'b1,
                                1'b1, '0, '0, '0));

    phases = '{
      '{8'd7,   8'd4,   150, 1'b0},
      '{8'd32,  8'd8,   150, 1'b0},
      '{8'd1,   8'd1,   150, 1'b1},
      '{8'hC0,  8'h00,  100, 1'b0},
      '{8'h3F,  8'h0F,  100, 1'b0},
      '{8'd20,  8'd3,   200, 1'b1},
      '{8'd5,   8'd2,   200, 1'b0},
      '{8'd32,  8'd1,   150, 1'b0},
      '{8'd12,  8'd5,   200, 1'b0},
      '{8'hFF,  8'hF6,  150, 1'b0},
      '{8'd16,  8'd7,   100, 1'b1}
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) push_beat(directed_rows[i]);
    for (int i = 0; i < cbmd_pkg::Depth; i++) begin
      push_beat(row(cbmd_pkg::FUNC_LOAD, cbmd_pkg::MsgW'(i), $urandom,
                    cbmd_pkg::MsgW'($urandom), $urandom, 1'($urandom), 1'b0, '0, '0, '0));
    end

    foreach (phases[p]) begin
      if (p != 0) begin
        settle();
        write_reg(cbmd_pkg::CfgCodeLength, phases[p].n_data);
        write_reg(cbmd_pkg::CfgMessageLength, phases[p].k_data);
      end
      steady = phases[p].steady;
      repeat (phases[p].count) begin
        if ($urandom_range(0, 49) == 0) settle();
        push_beat(random_beat());
      end
    end

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_answers.size() != 0) begin
      $error("%0d expected results never arrived", pending_answers.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
sv/cbmd_pkg.sv
sv/codebook_block_code_min_distance.sv
tb/sv/codebook_block_code_min_distance_test.sv
